// ===== hdl/saq_pkg.sv =====
// ----------------------------------------------------------------------------
// saq_pkg: shared types and constants for the sorted alarm queue
// Entry layout, cell command codes and request function codes.
// ----------------------------------------------------------------------------
package saq_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int TIME_W      = 32;
    localparam int ID_W        = 8;

    // request function codes
    localparam logic FUNC_TICK     = 1'b0;
    localparam logic FUNC_REGISTER = 1'b1;

    // one queue slot
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] rem;
        logic [TIME_W-1:0] per;
        logic              rep;
        logic [ID_W-1:0]   id;
    } entry_t;

    // what every cell does this cycle
    typedef enum logic [2:0] {
        OP_HOLD,        // keep contents
        OP_TICK,        // count down in place
        OP_INSERT,      // sorted insert of a new alarm
        OP_POP,         // front fired, shift toward the front
        OP_POP_REINS    // front fired and repeats: shift and re-insert
    } cell_op_t;

    // broadcast command to the chain
    typedef struct packed {
        cell_op_t op;
        entry_t   ins;  // entry to insert, ins.rem is the sort key
    } cell_cmd_t;

    function automatic logic [TIME_W-1:0] sat_dec(input logic [TIME_W-1:0] v);
        sat_dec = (v == '0) ? '0 : v - TIME_W'(1);
    endfunction

endpackage

// ===== hdl/saq_cell.sv =====
// ----------------------------------------------------------------------------
// saq_cell: one slot of the sorted alarm chain
// Holds one entry; inserts, counts down or shifts from a neighbor per command.
// ----------------------------------------------------------------------------
module saq_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  saq_pkg::cell_cmd_t cmd,
    input  saq_pkg::entry_t   left,      // slot k-1
    input  saq_pkg::entry_t   right,     // slot k+1
    input  logic              left_gt,   // slot k-1 is past the insert point
    output saq_pkg::entry_t   entry,
    output logic              gt         // this slot is past the insert point
);

    saq_pkg::entry_t entry_reg;
    saq_pkg::entry_t entry_next;
    saq_pkg::entry_t self_dec;
    saq_pkg::entry_t right_dec;

    always_comb
    begin
        self_dec      = entry_reg;
        self_dec.rem  = saq_pkg::sat_dec(entry_reg.rem);
        right_dec     = right;
        right_dec.rem = saq_pkg::sat_dec(right.rem);

        case (cmd.op)
            saq_pkg::OP_INSERT:
                gt = !entry_reg.valid || (cmd.ins.rem < entry_reg.rem);
            saq_pkg::OP_POP_REINS:
                gt = !right.valid || (cmd.ins.rem < right_dec.rem);
            default:
                gt = 1'b0;
        endcase

        case (cmd.op)
            saq_pkg::OP_TICK:
                entry_next = self_dec;
            saq_pkg::OP_POP:
                entry_next = right_dec;
            saq_pkg::OP_INSERT:
            begin
                if (gt && !left_gt)
                    entry_next = cmd.ins;
                else if (left_gt)
                    entry_next = left;
                else
                    entry_next = entry_reg;
            end
            saq_pkg::OP_POP_REINS:
            begin
                if (gt && !left_gt)
                    entry_next = cmd.ins;
                else if (left_gt)
                    entry_next = self_dec;
                else
                    entry_next = right_dec;
            end
            default:
                entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_reg <= '0;
        else
            entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== hdl/sorted_alarm_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_alarm_queue: hardware software-timer list sorted by remaining ticks
// Row of compare-and-shift cells that register, count down and fire alarms.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready): func selects a tick (0) or the
//   registration of a new alarm (1) with duration and repeat_req.
//   Response channel (rsp_valid/rsp_ready): exactly one response per
//   request. A registration returns accepted/assigned_id (accepted is 0
//   when the queue is full; the id is consumed anyway). A tick returns
//   fired/fired_id for at most one alarm, the one at the front.
//   Response: the response is registered and shows up in the cycle after the
//   request is taken. Throughput: one request per cycle while no response
//   waits unread; every cell does its compare, count-down and shift in the same
//   cycle, so the cell compare plus one 32-bit decrement sets the cycle time.
//   Stall: the response register is the only buffer. While a response waits
//   unread, req_ready drops; it rises again in the cycle the response is taken,
//   so a new request can be taken in the same cycle.
//   Reset: all slots empty, the next id is 1, no response pending.
// ----------------------------------------------------------------------------
module sorted_alarm_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic        func,
    input  logic [31:0] duration,
    input  logic        repeat_req,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic        accepted,
    output logic [7:0]  assigned_id,
    output logic        fired,
    output logic [7:0]  fired_id
);

    localparam int D = saq_pkg::QUEUE_DEPTH;

    saq_pkg::entry_t   slot [D];
    logic [D-1:0]      slot_gt;
    logic [D-1:0]      slot_vld;
    saq_pkg::cell_cmd_t cmd;

    logic req_take;
    logic is_reg;
    logic full;
    logic front_fire;

    logic                      rsp_valid_reg, rsp_valid_next;
    logic                      accepted_reg, accepted_next;
    logic [saq_pkg::ID_W-1:0]  assigned_id_reg, assigned_id_next;
    logic                      fired_reg, fired_next;
    logic [saq_pkg::ID_W-1:0]  fired_id_reg, fired_id_next;
    logic [saq_pkg::ID_W-1:0]  next_id_reg, next_id_next;

    // ---------------- cell chain ----------------
    genvar k;
    generate
        for (k = 0; k < D; k++)
        begin : g_cell
            saq_pkg::entry_t left_e;
            saq_pkg::entry_t right_e;
            logic            left_g;

            if (k == 0)
            begin : g_first
                assign left_e = '0;
                assign left_g = 1'b0;
            end
            else
            begin : g_mid
                assign left_e = slot[k-1];
                assign left_g = slot_gt[k-1];
            end

            if (k == D - 1)
            begin : g_last
                assign right_e = '0;   // beyond the end reads as empty
            end
            else
            begin : g_inner
                assign right_e = slot[k+1];
            end

            saq_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .cmd     (cmd),
                .left    (left_e),
                .right   (right_e),
                .left_gt (left_g),
                .entry   (slot[k]),
                .gt      (slot_gt[k])
            );

            assign slot_vld[k] = slot[k].valid;
        end
    endgenerate

    // ---------------- request decode ----------------
    assign req_ready  = !rsp_valid_reg || rsp_ready;
    assign req_take   = req_valid && req_ready;
    assign is_reg     = (func == saq_pkg::FUNC_REGISTER);
    assign full       = slot_vld[D-1];
    // front is due when its count reaches zero after this tick
    assign front_fire = slot[0].valid && (slot[0].rem <= saq_pkg::TIME_W'(1));

    always_comb
    begin
        cmd.ins.valid = 1'b1;
        if (is_reg)
        begin
            cmd.ins.rem = duration;
            cmd.ins.per = duration;
            cmd.ins.rep = repeat_req;
            cmd.ins.id  = next_id_reg;
        end
        else
        begin
            // repeat alarm goes back in with its reload value
            cmd.ins.rem = slot[0].per;
            cmd.ins.per = slot[0].per;
            cmd.ins.rep = 1'b1;
            cmd.ins.id  = slot[0].id;
        end

        if (!req_take)
            cmd.op = saq_pkg::OP_HOLD;
        else if (is_reg)
            cmd.op = full ? saq_pkg::OP_HOLD : saq_pkg::OP_INSERT;
        else if (front_fire)
            cmd.op = slot[0].rep ? saq_pkg::OP_POP_REINS : saq_pkg::OP_POP;
        else
            cmd.op = saq_pkg::OP_TICK;
    end

    // ---------------- response and id counter ----------------
    always_comb
    begin
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        accepted_next    = accepted_reg;
        assigned_id_next = assigned_id_reg;
        fired_next       = fired_reg;
        fired_id_next    = fired_id_reg;
        next_id_next     = next_id_reg;

        if (req_take)
        begin
            rsp_valid_next = 1'b1;
            if (is_reg)
            begin
                next_id_next     = next_id_reg + saq_pkg::ID_W'(1);
                accepted_next    = !full;
                assigned_id_next = full ? '0 : next_id_reg;
                fired_next       = 1'b0;
                fired_id_next    = '0;
            end
            else
            begin
                accepted_next    = 1'b0;
                assigned_id_next = '0;
                fired_next       = front_fire;
                fired_id_next    = front_fire ? slot[0].id : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            next_id_reg   <= saq_pkg::ID_W'(1);
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            next_id_reg   <= next_id_next;
        end
    end

    always_ff @(posedge clk)
    begin
        accepted_reg    <= accepted_next;
        assigned_id_reg <= assigned_id_next;
        fired_reg       <= fired_next;
        fired_id_reg    <= fired_id_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign accepted    = accepted_reg;
    assign assigned_id = assigned_id_reg;
    assign fired       = fired_reg;
    assign fired_id    = fired_id_reg;

    // ---------------- assertions ----------------
    logic [D:0] vld_plus1;
    assign vld_plus1 = {1'b0, slot_vld} + (D+1)'(1);

    // occupied slots always form a block starting at the front
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(vld_plus1))
        else $error("queue slots not packed toward the front");

    // a response never reports both a registration and a firing
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(accepted && fired))
        else $error("accepted and fired both set");

    // a rejected registration leaves the queue untouched
    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (req_take && is_reg && full) |=> $stable(slot_vld))
        else $error("rejected alarm changed the queue");

    // a stored registration leaves the front occupied
    a_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (req_take && is_reg && !full) |=> slot_vld[0])
        else $error("insert left the queue empty");

    // entries stay sorted by remaining ticks
    generate
        for (k = 0; k < D - 1; k++)
        begin : g_chk
            a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
                slot_vld[k+1] |-> (slot[k].rem <= slot[k+1].rem))
                else $error("queue order broken");
        end
    endgenerate

endmodule

// ===== bench/sorted_alarm_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_alarm_queue_tb: self-checking bench for the sorted alarm queue
// Sends tick and register requests over valid/ready, keeps its own sorted
// alarm list to predict each response, and checks every response in order.
// ----------------------------------------------------------------------------
module sorted_alarm_queue_tb;

    // one expected or observed response
    typedef struct packed {
        logic       accepted;
        logic [7:0] assigned_id;
        logic       fired;
        logic [7:0] fired_id;
    } alarm_rsp_t;

    // alarms living longer than this never expire within the run
    localparam logic [31:0] LONG_TICKS   = 32'd1000;
    // long or repeating alarms hold a slot for good; keep their number low
    localparam int          STICKY_LIMIT = 4;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    logic        func = saq_pkg::FUNC_TICK;
    logic [31:0] duration = '0;
    logic        repeat_req = 1'b0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    logic        accepted;
    logic [7:0]  assigned_id;
    logic        fired;
    logic [7:0]  fired_id;

    // predicted alarm list, front at index 0
    logic [31:0] timers_rem [saq_pkg::QUEUE_DEPTH];
    logic [31:0] timers_per [saq_pkg::QUEUE_DEPTH];
    logic        timers_rep [saq_pkg::QUEUE_DEPTH];
    logic [7:0]  timers_id  [saq_pkg::QUEUE_DEPTH];
    int          timer_count;
    logic [7:0]  next_id;

    alarm_rsp_t  pending_rsps [$];

    int send_idle_pct = 0;
    int rsp_stall_pct = 0;
    int errors = 0;
    int rsp_count = 0;
    int stat_fired = 0;
    int stat_refused = 0;
    int stat_wraps = 0;

    sorted_alarm_queue i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .func        (func),
        .duration    (duration),
        .repeat_req  (repeat_req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .accepted    (accepted),
        .assigned_id (assigned_id),
        .fired       (fired),
        .fired_id    (fired_id)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // global watchdog, far beyond the slowest legal run
    initial
    begin
        #(64'd5_000_000);
        $display("timeout: %0d responses still outstanding", pending_rsps.size());
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // sorted insert, after every entry with equal or smaller time
    task automatic insert_timer(input logic [31:0] rem, input logic [31:0] per,
                                input logic rep, input logic [7:0] id);
        int  pos;
        bit  found;
        pos = timer_count;
        found = 1'b0;
        for (int k = 0; k < timer_count; k++)
        begin
            if (!found && rem < timers_rem[k])
            begin
                pos = k;
                found = 1'b1;
            end
        end
        for (int k = timer_count; k > pos; k--)
        begin
            timers_rem[k] = timers_rem[k-1];
            timers_per[k] = timers_per[k-1];
            timers_rep[k] = timers_rep[k-1];
            timers_id[k]  = timers_id[k-1];
        end
        timers_rem[pos] = rem;
        timers_per[pos] = per;
        timers_rep[pos] = rep;
        timers_id[pos]  = id;
        timer_count++;
    endtask

    task automatic drop_front_timer();
        for (int k = 0; k + 1 < timer_count; k++)
        begin
            timers_rem[k] = timers_rem[k+1];
            timers_per[k] = timers_per[k+1];
            timers_rep[k] = timers_rep[k+1];
            timers_id[k]  = timers_id[k+1];
        end
        timer_count--;
        timers_rem[timer_count] = '0;
        timers_per[timer_count] = '0;
        timers_rep[timer_count] = 1'b0;
        timers_id[timer_count]  = '0;
    endtask

    // apply one accepted request to the list and queue its response
    task automatic predict_request(input logic f, input logic [31:0] dur, input logic rep);
        alarm_rsp_t  rsp;
        logic [31:0] f_per;
        logic        f_rep;
        logic [7:0]  f_id;
        rsp = '0;
        if (f == saq_pkg::FUNC_REGISTER)
        begin
            if (next_id == 8'hFF)
                stat_wraps++;
            if (timer_count < saq_pkg::QUEUE_DEPTH)
            begin
                insert_timer(dur, dur, rep, next_id);
                rsp.accepted    = 1'b1;
                rsp.assigned_id = next_id;
            end
            else
                stat_refused++;     // id is burned even on refusal
            next_id = next_id + 8'd1;
        end
        else if (timer_count > 0)
        begin
            for (int k = 0; k < timer_count; k++)
            begin
                if (timers_rem[k] != '0)
                    timers_rem[k] = timers_rem[k] - 32'd1;
            end
            // only the front may fire; others at zero wait their turn
            if (timers_rem[0] == '0)
            begin
                f_per = timers_per[0];
                f_rep = timers_rep[0];
                f_id  = timers_id[0];
                rsp.fired    = 1'b1;
                rsp.fired_id = f_id;
                stat_fired++;
                drop_front_timer();
                if (f_rep)
                    insert_timer(f_per, f_per, f_rep, f_id);
            end
        end
        pending_rsps.push_back(rsp);
    endtask

    function automatic int sticky_timers();
        int n;
        n = 0;
        for (int k = 0; k < timer_count; k++)
        begin
            if (timers_rep[k] || timers_rem[k] > LONG_TICKS)
                n++;
        end
        return n;
    endfunction

    // ------------------------------------------------------------------
    // request driver: one request, with random idle cycles ahead of it
    // ------------------------------------------------------------------
    task automatic send_req(input logic f, input logic [31:0] dur, input logic rep);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            // idle: drop valid and scramble the payload
            req_valid  <= 1'b0;
            func       <= 1'($urandom_range(0, 1));
            duration   <= $urandom;
            repeat_req <= 1'($urandom_range(0, 1));
            @(negedge clk);
        end
        req_valid  <= 1'b1;
        func       <= f;
        duration   <= dur;
        repeat_req <= rep;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predict_request(f, dur, rep);
    endtask

    // ------------------------------------------------------------------
    // response side: random back-pressure and in-order checking
    // ------------------------------------------------------------------
    always @(negedge clk)
        rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);

    always @(posedge clk)
    begin
        alarm_rsp_t got;
        alarm_rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            got = '{accepted, assigned_id, fired, fired_id};
            rsp_count++;
            if (pending_rsps.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display({"%0t: response with nothing outstanding: ",
                              "acc=%0b id=%0d fired=%0b fid=%0d"},
                             $realtime, got.accepted, got.assigned_id, got.fired,
                             got.fired_id);
            end
            else
            begin
                want = pending_rsps.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"%0t: mismatch exp acc=%0b id=%0d fired=%0b fid=%0d",
                                  " / got acc=%0b id=%0d fired=%0b fid=%0d"},
                                 $realtime, want.accepted, want.assigned_id, want.fired,
                                 want.fired_id, got.accepted, got.assigned_id, got.fired,
                                 got.fired_id);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // empty tick, zero duration, equal-time ordering, several entries at zero
    task automatic test_fire_order();
        send_req(saq_pkg::FUNC_TICK, 32'hFFFF_FFFF, 1'b1);   // empty queue, junk payload
        send_req(saq_pkg::FUNC_REGISTER, 32'd0, 1'b0);       // fires on next tick
        send_req(saq_pkg::FUNC_TICK, '0, 1'b0);
        send_req(saq_pkg::FUNC_REGISTER, 32'd5, 1'b0);
        send_req(saq_pkg::FUNC_REGISTER, 32'd5, 1'b0);       // goes behind the first 5
        send_req(saq_pkg::FUNC_REGISTER, 32'd2, 1'b0);       // goes to the front
        for (int k = 0; k < 6; k++)
            send_req(saq_pkg::FUNC_TICK, '0, 1'b0);
    endtask

    // longest duration, a repeating reload, then a full queue refusal
    task automatic test_repeat_and_full();
        send_req(saq_pkg::FUNC_REGISTER, 32'hFFFF_FFFF, 1'b0);
        send_req(saq_pkg::FUNC_REGISTER, 32'd3, 1'b1);
        for (int k = 0; k < 3; k++)
            send_req(saq_pkg::FUNC_TICK, '0, 1'b0);
        send_req(saq_pkg::FUNC_REGISTER, 32'd10, 1'b0);
        send_req(saq_pkg::FUNC_REGISTER, 32'd10, 1'b0);
        send_req(saq_pkg::FUNC_REGISTER, 32'd1, 1'b0);
        send_req(saq_pkg::FUNC_REGISTER, 32'd7, 1'b0);
        send_req(saq_pkg::FUNC_REGISTER, 32'd12, 1'b0);
        send_req(saq_pkg::FUNC_REGISTER, 32'd0, 1'b0);       // queue now full
        send_req(saq_pkg::FUNC_REGISTER, 32'd4, 1'b1);       // refused, id still used
    endtask

    // mixed traffic; register density swings so the queue fills and drains
    task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n);
        int          reg_pct;
        logic [31:0] dur;
        logic        rep;
        send_idle_pct = idle_pct;
        rsp_stall_pct = stall_pct;
        reg_pct = 50;
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
                reg_pct = 30 + 20 * $urandom_range(0, 2);
            if ($urandom_range(0, 99) < reg_pct)
            begin
                dur = $urandom_range(0, 40);
                rep = 1'b0;
                if (sticky_timers() < STICKY_LIMIT && $urandom_range(0, 99) < 3)
                begin
                    if ($urandom_range(0, 1))
                    begin
                        rep = 1'b1;
                        dur = $urandom_range(1, 20);
                    end
                    else
                        dur = $urandom;
                end
                send_req(saq_pkg::FUNC_REGISTER, dur, rep);
            end
            else
                send_req(saq_pkg::FUNC_TICK, $urandom, 1'($urandom_range(0, 1)));
        end
    endtask

    // zero-duration repeat fires every tick it reaches the front; run last
    // since it never leaves the queue
    task automatic test_zero_repeat();
        while (timer_count > saq_pkg::QUEUE_DEPTH - 2)
            send_req(saq_pkg::FUNC_TICK, '0, 1'b0);
        send_req(saq_pkg::FUNC_REGISTER, 32'd0, 1'b1);
        send_req(saq_pkg::FUNC_REGISTER, 32'd0, 1'b0);
        for (int k = 0; k < 4; k++)
            send_req(saq_pkg::FUNC_TICK, '0, 1'b0);
    endtask

    initial
    begin
        for (int k = 0; k < saq_pkg::QUEUE_DEPTH; k++)
        begin
            timers_rem[k] = '0;
            timers_per[k] = '0;
            timers_rep[k] = 1'b0;
            timers_id[k]  = '0;
        end
        timer_count = 0;
        next_id = 8'd1;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 16;
        rsp_stall_pct = 16;
        test_fire_order();
        test_repeat_and_full();
        test_random_traffic(0, 0, 190);
        test_random_traffic(82, 0, 185);
        test_random_traffic(0, 82, 185);
        test_random_traffic(16, 16, 190);
        test_zero_repeat();

        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_rsps.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        $display("checked %0d responses: %0d alarms fired, %0d registrations refused",
                 rsp_count, stat_fired, stat_refused);
        $display("id counter wrapped %0d times; four idle/stall mixes exercised", stat_wraps);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/saq_pkg.sv
hdl/saq_cell.sv
hdl/sorted_alarm_queue.sv
bench/sorted_alarm_queue_tb.sv
